### sv/hvhs_pkg.sv
// shared types, constants and helper functions of the veto hit search block
package hvhs_pkg;

   localparam int PE_WIDTH    = 16;
   localparam int COUNT_WIDTH = 12;
   localparam int THR_WIDTH   = 16;
   localparam int CMP_WIDTH   = (PE_WIDTH > THR_WIDTH) ? PE_WIDTH : THR_WIDTH;

   localparam int LAYER_WIDTH = 7;
   localparam int STRIP_WIDTH = 6;
   localparam int QUAD_WIDTH  = 5;
   localparam int COST_WIDTH  = 12;
   localparam int BQUAD_WIDTH = 6;
   localparam int BAND_WIDTH  = 8;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};
   localparam logic [COST_WIDTH-1:0]  COST_START   = COST_WIDTH'(4000);
   localparam logic [BQUAD_WIDTH-1:0] QUADS_START  = BQUAD_WIDTH'(40);
   localparam logic [LAYER_WIDTH-1:0] CLAYER_START = LAYER_WIDTH'(100);
   localparam logic [STRIP_WIDTH-1:0] CENTER_HI    = STRIP_WIDTH'(20);
   localparam logic [STRIP_WIDTH-1:0] CENTER_LO    = STRIP_WIDTH'(19);

   localparam logic [3:0]            MODE_RESET  = 4'd0;
   localparam logic [2:0]            NMOD_RESET  = 3'd6;
   localparam logic [THR_WIDTH-1:0]  THR_RESET   = THR_WIDTH'(160);

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_REGION_MODE  = 2'd0,
      CSR_MODULE_COUNT = 2'd1,
      CSR_PE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      REGION_ENTIRE_BACK   = 4'd0,
      REGION_NARROW_BACK   = 4'd1,
      REGION_SIX_ONLY      = 4'd2,
      REGION_FUNNEL        = 4'd3,
      REGION_FUNNEL_SIDE   = 4'd4,
      REGION_NARROW_FUNNEL = 4'd5,
      REGION_NARROW_SIDE   = 4'd6,
      REGION_MEGAPHONE     = 4'd7,
      REGION_PROTOTYPE     = 4'd8
   } region_mode_type;

   typedef struct packed {
      logic                   hit_present;
      logic [2:0]             section;
      logic [LAYER_WIDTH-1:0] layer;
      logic [STRIP_WIDTH-1:0] strip;
      logic [PE_WIDTH-1:0]    pe;
      logic                   last_hit;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] veto_hit_count;
      logic [PE_WIDTH-1:0]    back_max_pe;
      logic                   cheapest_found;
      logic [STRIP_WIDTH-1:0] cheapest_strip;
      logic [LAYER_WIDTH-1:0] cheapest_layer;
      logic                   central_found;
      logic [STRIP_WIDTH-1:0] central_strip;
      logic [LAYER_WIDTH-1:0] central_layer;
      logic [PE_WIDTH-1:0]    region_max_pe;
      logic                   region_pass;
   } rsp_item_type;

   typedef struct packed {
      logic [3:0]            region_mode;
      logic [2:0]            module_count;
      logic [THR_WIDTH-1:0]  pe_threshold;
   } csr_regs_type;

   // classified hit handed from the classifier to the accumulators
   typedef struct packed {
      logic                   back_hit;
      logic                   veto_hit;
      logic                   region_hit;
      logic                   last_hit;
      logic [QUAD_WIDTH-1:0]  quads;
      logic [COST_WIDTH-1:0]  cost;
      logic [LAYER_WIDTH-1:0] layer;
      logic [STRIP_WIDTH-1:0] strip;
      logic [PE_WIDTH-1:0]    pe;
   } hit_info_type;

   // quad bars from the centre, which lies between strips 19 and 20
   function automatic logic [QUAD_WIDTH-1:0] quads_of(input logic [STRIP_WIDTH-1:0] strip);
      logic [STRIP_WIDTH-1:0] span;
      span = (strip >= CENTER_HI) ? (strip - CENTER_HI) : (CENTER_LO - strip);
      return QUAD_WIDTH'(span[STRIP_WIDTH-1:1]) + QUAD_WIDTH'(1);
   endfunction

   function automatic logic pe_below(input logic [PE_WIDTH-1:0] pe,
                                     input logic [THR_WIDTH-1:0] thr);
      return CMP_WIDTH'(pe) < CMP_WIDTH'(thr);
   endfunction

endpackage

### sv/hvhs_csr.sv
// configuration registers behind the apb-style port
module hvhs_csr import hvhs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output csr_regs_type              regs
);

   csr_regs_type  regs_ff;
   csr_regs_type  regs_in;
   csr_index_type index;
   logic          write_en;

   assign index      = csr_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign regs       = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (write_en) begin
         unique case (index)
            CSR_REGION_MODE:  regs_in.region_mode  = csr_pwdata[3:0];
            CSR_MODULE_COUNT: regs_in.module_count = csr_pwdata[2:0];
            CSR_PE_THRESHOLD: regs_in.pe_threshold = csr_pwdata[THR_WIDTH-1:0];
            default:          regs_in = regs_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_REGION_MODE:  csr_prdata = CSR_DATA_WIDTH'(regs_ff.region_mode);
         CSR_MODULE_COUNT: csr_prdata = CSR_DATA_WIDTH'(regs_ff.module_count);
         CSR_PE_THRESHOLD: csr_prdata = CSR_DATA_WIDTH'(regs_ff.pe_threshold);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.region_mode  <= MODE_RESET;
         regs_ff.module_count <= NMOD_RESET;
         regs_ff.pe_threshold <= THR_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

### sv/hvhs_classify.sv
// per-hit classification: quads, cost, veto flag and region membership
module hvhs_classify import hvhs_pkg::*; (
   input  req_item_type item,
   input  csr_regs_type regs,
   output hit_info_type info
);

   logic                  back;
   logic [QUAD_WIDTH-1:0] quads;
   logic [BAND_WIDTH-1:0] layer_x;
   logic [BAND_WIDTH-1:0] base;
   logic                  funnel_wide;
   logic                  funnel_narrow;
   logic                  proto_near;
   logic                  mega;
   logic                  in_region;

   assign back    = (item.section == 3'd0);
   assign quads   = quads_of(item.strip);
   assign layer_x = BAND_WIDTH'(item.layer);
   assign base    = BAND_WIDTH'({regs.module_count, 3'b000});

   always_comb begin
      priority if (layer_x < base + BAND_WIDTH'(1)) begin
         funnel_wide   = 1'b1;
         funnel_narrow = (quads < QUAD_WIDTH'(9));
      end else if (layer_x < base + BAND_WIDTH'(11)) begin
         funnel_wide   = (quads < QUAD_WIDTH'(4));
         funnel_narrow = funnel_wide;
      end else if (layer_x < base + BAND_WIDTH'(20)) begin
         funnel_wide   = (quads < QUAD_WIDTH'(3));
         funnel_narrow = funnel_wide;
      end else begin
         funnel_wide   = 1'b0;
         funnel_narrow = 1'b0;
      end
   end

   always_comb begin
      priority if (item.layer < LAYER_WIDTH'(10)) begin
         proto_near = (quads < QUAD_WIDTH'(3));
         mega       = proto_near;
      end else if (item.layer < LAYER_WIDTH'(20)) begin
         proto_near = (quads < QUAD_WIDTH'(4));
         mega       = proto_near;
      end else begin
         proto_near = 1'b0;
         mega       = (item.layer < LAYER_WIDTH'(68));
      end
   end

   always_comb begin
      unique case (region_mode_type'(regs.region_mode))
         REGION_ENTIRE_BACK:   in_region = back;
         REGION_NARROW_BACK:   in_region = back && (quads < QUAD_WIDTH'(9));
         REGION_SIX_ONLY:      in_region = back && (item.layer < LAYER_WIDTH'(49));
         REGION_FUNNEL:        in_region = back && funnel_wide;
         REGION_FUNNEL_SIDE:   in_region = back ? funnel_wide
                                                : (item.layer < LAYER_WIDTH'(7));
         REGION_NARROW_FUNNEL: in_region = back && funnel_narrow;
         REGION_NARROW_SIDE:   in_region = back ? funnel_narrow
                                                : (item.layer < LAYER_WIDTH'(7));
         REGION_MEGAPHONE:     in_region = back && mega;
         REGION_PROTOTYPE:     in_region = back && proto_near;
         default:              in_region = 1'b0;
      endcase
   end

   always_comb begin
      info.back_hit   = item.hit_present && back;
      info.veto_hit   = item.hit_present && back && !pe_below(item.pe, regs.pe_threshold);
      info.region_hit = item.hit_present && in_region;
      info.last_hit   = item.last_hit;
      info.quads      = quads;
      info.cost       = COST_WIDTH'(item.layer) * COST_WIDTH'(quads);
      info.layer      = item.layer;
      info.strip      = item.strip;
      info.pe         = item.pe;
   end

endmodule

### sv/hvhs_accum.sv
// event accumulators and the registered event summary
module hvhs_accum import hvhs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 info_valid,
   input  hit_info_type         info,
   input  logic [THR_WIDTH-1:0] pe_threshold,
   output logic                 info_go,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_data
);

   logic [PE_WIDTH-1:0]    back_max_ff,     back_max_in;
   logic [COUNT_WIDTH-1:0] count_ff,        count_in;
   logic [COST_WIDTH-1:0]  best_cost_ff,    best_cost_in;
   logic                   cost_found_ff,   cost_found_in;
   logic [STRIP_WIDTH-1:0] cost_strip_ff,   cost_strip_in;
   logic [LAYER_WIDTH-1:0] cost_layer_ff,   cost_layer_in;
   logic [BQUAD_WIDTH-1:0] best_quads_ff,   best_quads_in;
   logic [LAYER_WIDTH-1:0] best_clayer_ff,  best_clayer_in;
   logic                   cen_found_ff,    cen_found_in;
   logic [STRIP_WIDTH-1:0] cen_strip_ff,    cen_strip_in;
   logic [LAYER_WIDTH-1:0] cen_layer_ff,    cen_layer_in;
   logic [PE_WIDTH-1:0]    region_max_ff,   region_max_in;
   logic                   rsp_valid_ff,    rsp_valid_in;
   rsp_item_type           rsp_data_ff,     rsp_data_in;
   logic                   fire;
   logic                   closing;
   logic [BQUAD_WIDTH-1:0] q_ext;

   // a last item waits only while the summary register is still held
   assign info_go   = !(info.last_hit && rsp_valid_ff && rsp_stall);
   assign fire      = info_valid && info_go;
   assign closing   = fire && info.last_hit;
   assign q_ext     = BQUAD_WIDTH'(info.quads);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      back_max_in    = back_max_ff;
      count_in       = count_ff;
      best_cost_in   = best_cost_ff;
      cost_found_in  = cost_found_ff;
      cost_strip_in  = cost_strip_ff;
      cost_layer_in  = cost_layer_ff;
      best_quads_in  = best_quads_ff;
      best_clayer_in = best_clayer_ff;
      cen_found_in   = cen_found_ff;
      cen_strip_in   = cen_strip_ff;
      cen_layer_in   = cen_layer_ff;
      region_max_in  = region_max_ff;

      if (info.back_hit && (info.pe > back_max_ff)) begin
         back_max_in = info.pe;
      end
      if (info.veto_hit) begin
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_WIDTH'(1);
         end
         if (info.cost < best_cost_ff) begin
            best_cost_in  = info.cost;
            cost_found_in = 1'b1;
            cost_strip_in = info.strip;
            cost_layer_in = info.layer;
         end
         if ((q_ext < best_quads_ff) ||
             ((q_ext == best_quads_ff) && (info.layer < best_clayer_ff))) begin
            best_quads_in  = q_ext;
            best_clayer_in = info.layer;
            cen_found_in   = 1'b1;
            cen_strip_in   = info.strip;
            cen_layer_in   = info.layer;
         end
      end
      if (info.region_hit && (info.pe > region_max_ff)) begin
         region_max_in = info.pe;
      end
   end

   always_comb begin
      rsp_data_in.veto_hit_count = count_in;
      rsp_data_in.back_max_pe    = back_max_in;
      rsp_data_in.cheapest_found = cost_found_in;
      rsp_data_in.cheapest_strip = cost_strip_in;
      rsp_data_in.cheapest_layer = cost_layer_in;
      rsp_data_in.central_found  = cen_found_in;
      rsp_data_in.central_strip  = cen_strip_in;
      rsp_data_in.central_layer  = cen_layer_in;
      rsp_data_in.region_max_pe  = region_max_in;
      rsp_data_in.region_pass    = pe_below(region_max_in, pe_threshold);

      priority if (closing) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || closing) begin
         back_max_ff    <= '0;
         count_ff       <= '0;
         best_cost_ff   <= COST_START;
         cost_found_ff  <= 1'b0;
         cost_strip_ff  <= '0;
         cost_layer_ff  <= '0;
         best_quads_ff  <= QUADS_START;
         best_clayer_ff <= CLAYER_START;
         cen_found_ff   <= 1'b0;
         cen_strip_ff   <= '0;
         cen_layer_ff   <= '0;
         region_max_ff  <= '0;
      end else if (fire) begin
         back_max_ff    <= back_max_in;
         count_ff       <= count_in;
         best_cost_ff   <= best_cost_in;
         cost_found_ff  <= cost_found_in;
         cost_strip_ff  <= cost_strip_in;
         cost_layer_ff  <= cost_layer_in;
         best_quads_ff  <= best_quads_in;
         best_clayer_ff <= best_clayer_in;
         cen_found_ff   <= cen_found_in;
         cen_strip_ff   <= cen_strip_in;
         cen_layer_ff   <= cen_layer_in;
         region_max_ff  <= region_max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (closing) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### sv/hcal_veto_hit_search_top.sv
// top level of the calorimeter veto hit search
//
// hits of one event enter on the req_ channel, one item per clock when
// req_valid is high and req_stall is low; an item with last_hit set closes
// the event. items without last_hit give no result. an item with
// hit_present low only carries the event end.
// one summary item leaves on the rsp_ channel per closed event: veto hit
// count, back maximum pe, least-cost hit, most central hit and the region
// maximum with its pass flag.
// an item is registered in the input register at acceptance, then classified
// and folded into the event accumulators; the summary register is loaded as
// the last item leaves the input register. throughput is one item per clock
// while no last item waits behind a stalled summary.
// when rsp_stall holds a summary, hits keep flowing; only a further last
// item waits in the input register, and req_stall rises behind it.
// region mode, module count and pe threshold sit on the csr_ port; the user must
// write them only while no event is in flight: the block does not enforce it.
// synchronous reset clears the pipeline, the accumulators and the
// configuration registers to their defaults.
module hcal_veto_hit_search_top import hvhs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_item_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_item_type              rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   csr_regs_type regs;
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   hit_info_type info;
   logic         s1_go;
   logic         req_accept;

   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      priority if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_data;
      end
   end

   hvhs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   hvhs_classify u_classify (
      .item (s1_item_ff),
      .regs (regs),
      .info (info)
   );

   hvhs_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .info_valid   (s1_valid_ff),
      .info         (info),
      .pe_threshold (regs.pe_threshold),
      .info_go      (s1_go),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

`ifndef SYNTHESIS
   // a new summary only follows a last item leaving the input register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff && s1_item_ff.last_hit))
      else $error("summary appeared without a closing item");

   // a held item stays in the input register unchanged
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("held item lost from input register");

   // only a last item can be held back, and only behind a stalled summary
   a_hold_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_item_ff.last_hit && rsp_valid && rsp_stall))
      else $error("input stalled without a blocked summary");
`endif

endmodule
